// ===== rtl/umpq_pkg.sv =====
// Shared types and constants for the unsorted max priority queue.
// No dependencies; used by umpq_cell and unsorted_max_priority_queue.
`default_nettype none

package umpq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;

   typedef enum logic [1:0] {
      MODE_PUSH  = 2'd0,
      MODE_POP   = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   // per-cell update strobes, decoded by the top level
   typedef struct packed {
      logic clear;
      logic load;
      logic shift;
   } cell_ctrl_type;

   // running maximum handed along the chain
   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] prio;
   } best_type;

endpackage

`default_nettype wire

// ===== rtl/umpq_cell.sv =====
// One queue slot: holds a value/priority pair, shifts down from its upper
// neighbor on a pop, and folds its entry into the running maximum. Uses umpq_pkg.
`default_nettype none

module umpq_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  wire                            clock,
   input  wire                            reset,
   input  umpq_pkg::cell_ctrl_type        ctrl,
   input  wire [umpq_pkg::DATA_W-1:0]     push_value,
   input  wire [umpq_pkg::DATA_W-1:0]     push_prio,
   input  wire                            nb_occ,
   input  wire [umpq_pkg::DATA_W-1:0]     nb_value,
   input  wire [umpq_pkg::DATA_W-1:0]     nb_prio,
   input  umpq_pkg::best_type             best_prev,
   input  wire [IDX_W-1:0]                best_idx_prev,
   output logic                           occ,
   output logic [umpq_pkg::DATA_W-1:0]    value,
   output logic [umpq_pkg::DATA_W-1:0]    prio,
   output umpq_pkg::best_type             best_next,
   output logic [IDX_W-1:0]               best_idx_next
);

   logic                        occ_ff, occ_in;
   logic [umpq_pkg::DATA_W-1:0] value_ff, value_in;
   logic [umpq_pkg::DATA_W-1:0] prio_ff, prio_in;
   umpq_pkg::best_type          best_ff, best_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;
   logic                        own_win;

   always_comb begin
      occ_in   = occ_ff;
      value_in = value_ff;
      prio_in  = prio_ff;
      if (ctrl.clear) begin
         occ_in = 1'b0;
      end else if (ctrl.load) begin
         occ_in   = 1'b1;
         value_in = push_value;
         prio_in  = push_prio;
      end else if (ctrl.shift) begin
         occ_in   = nb_occ;
         value_in = nb_value;
         prio_in  = nb_prio;
      end
   end

   // strict greater keeps the earliest entry among equal priorities
   assign own_win = occ_ff &&
                    (!best_prev.ok || ($signed(prio_ff) > $signed(best_prev.prio)));

   always_comb begin
      if (own_win) begin
         best_in.ok    = 1'b1;
         best_in.value = value_ff;
         best_in.prio  = prio_ff;
         best_idx_in   = IDX_W'(CELL_IDX);
      end else begin
         best_in     = best_prev;
         best_idx_in = best_idx_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= 1'b0;
         best_ff.ok <= 1'b0;
      end else begin
         occ_ff     <= occ_in;
         best_ff.ok <= best_in.ok;
      end
      value_ff      <= value_in;
      prio_ff       <= prio_in;
      best_ff.value <= best_in.value;
      best_ff.prio  <= best_in.prio;
      best_idx_ff   <= best_idx_in;
   end

   assign occ           = occ_ff;
   assign value         = value_ff;
   assign prio          = prio_ff;
   assign best_next     = best_ff;
   assign best_idx_next = best_idx_ff;

endmodule

`default_nettype wire

// ===== rtl/unsorted_max_priority_queue.sv =====
// Top level of the unsorted max priority queue: control FSM, fill count and
// the chain of umpq_cell slots. Uses umpq_pkg and umpq_cell.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | tuser: mode; tdata: value, priority
//  rsp     | out | rsp_tvalid / rsp_tready | tdata: head, status
//
// An item is applied to the cells on the accepting edge; the running maximum
// then ripples through the chain, one cell per cycle, and the result register
// is loaded once the scan is done. One item is in flight at a time. A result
// waiting on rsp_tready holds the block in place; the next item is taken once
// the result register has been loaded. Reset empties the queue.
`default_nettype none

module unsorted_max_priority_queue #(
   parameter int DEPTH = umpq_pkg::DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int RSP_W = ((2 * umpq_pkg::DATA_W + 3 + CNT_W + 7) / 8) * 8
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [2*umpq_pkg::DATA_W-1:0]      req_tdata,  // item_value, item_priority
   input  wire [1:0]                         req_tuser,  // mode
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // head_value, head_priority, head_valid, entry_total, queue_full, accepted, zero pad
   output logic [RSP_W-1:0]                  rsp_tdata
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW    = umpq_pkg::DATA_W;

   umpq_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [IDX_W-1:0]    head_idx_ff, head_idx_in;
   logic                ok_ff, ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                req_fire, scan_done, load_rsp;
   logic                do_push, do_pop, do_clear;
   umpq_pkg::mode_type  mode;
   logic [DW-1:0]       push_value, push_prio;

   umpq_pkg::cell_ctrl_type ctrl [DEPTH];
   logic                    occ_q [DEPTH];
   logic [DW-1:0]           val_q [DEPTH];
   logic [DW-1:0]           pri_q [DEPTH];
   umpq_pkg::best_type      best_q [DEPTH];
   logic [IDX_W-1:0]        bidx_q [DEPTH];

   assign mode       = umpq_pkg::mode_type'(req_tuser);
   assign push_value = req_tdata[DW-1:0];
   assign push_prio  = req_tdata[2*DW-1:DW];
   assign req_fire   = req_tvalid && req_tready;
   assign scan_done  = (scan_ff == CNT_W'(DEPTH));

   // operation decode
   always_comb begin
      do_push  = 1'b0;
      do_pop   = 1'b0;
      do_clear = 1'b0;
      ok_in    = ok_ff;
      count_in = count_ff;
      if (req_fire) begin
         ok_in = 1'b0;
         unique case (mode)
            umpq_pkg::MODE_PUSH: begin
               if (count_ff != CNT_W'(DEPTH)) begin
                  do_push  = 1'b1;
                  ok_in    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            umpq_pkg::MODE_POP: begin
               if (count_ff != '0) begin
                  do_pop   = 1'b1;
                  ok_in    = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            umpq_pkg::MODE_CLEAR: begin
               do_clear = 1'b1;
               ok_in    = 1'b1;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         umpq_pkg::ST_IDLE: if (req_fire) state_in = umpq_pkg::ST_SCAN;
         umpq_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = load_rsp ? umpq_pkg::ST_IDLE : umpq_pkg::ST_HOLD;
            end
         end
         umpq_pkg::ST_HOLD: if (load_rsp) state_in = umpq_pkg::ST_IDLE;
         default:           state_in = umpq_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         umpq_pkg::ST_IDLE: req_tready = 1'b1;
         umpq_pkg::ST_SCAN: load_rsp   = scan_done && (!rsp_valid_ff || rsp_tready);
         umpq_pkg::ST_HOLD: load_rsp   = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   always_comb begin
      scan_in = scan_ff;
      if (req_fire) begin
         scan_in = '0;
      end else if (state_ff == umpq_pkg::ST_SCAN && !scan_done) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   always_comb begin
      head_idx_in  = head_idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         head_idx_in  = bidx_q[DEPTH-1];
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({ok_ff,
                                (count_ff == CNT_W'(DEPTH)),
                                count_ff,
                                best_q[DEPTH-1].ok,
                                best_q[DEPTH-1].ok ? best_q[DEPTH-1].prio  : {DW{1'b0}},
                                best_q[DEPTH-1].ok ? best_q[DEPTH-1].value : {DW{1'b0}}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= umpq_pkg::ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         head_idx_ff  <= '0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         head_idx_ff  <= head_idx_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      umpq_pkg::best_type best_prev;
      logic [IDX_W-1:0]   bidx_prev;
      logic               nb_occ;
      logic [DW-1:0]      nb_val, nb_pri;

      assign ctrl[i].clear = do_clear;
      assign ctrl[i].load  = do_push && (count_ff == CNT_W'(i));
      assign ctrl[i].shift = do_pop && (IDX_W'(i) >= head_idx_ff);

      if (i == 0) begin : g_first
         assign best_prev = '0;
         assign bidx_prev = '0;
      end else begin : g_link
         assign best_prev = best_q[i-1];
         assign bidx_prev = bidx_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign nb_occ = 1'b0;
         assign nb_val = '0;
         assign nb_pri = '0;
      end else begin : g_up
         assign nb_occ = occ_q[i+1];
         assign nb_val = val_q[i+1];
         assign nb_pri = pri_q[i+1];
      end

      umpq_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl[i]),
         .push_value    (push_value),
         .push_prio     (push_prio),
         .nb_occ        (nb_occ),
         .nb_value      (nb_val),
         .nb_prio       (nb_pri),
         .best_prev     (best_prev),
         .best_idx_prev (bidx_prev),
         .occ           (occ_q[i]),
         .value         (val_q[i]),
         .prio          (pri_q[i]),
         .best_next     (best_q[i]),
         .best_idx_next (bidx_q[i])
      );
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for unsorted_max_priority_queue: random and directed
// push/pop/clear words, with a scoreboard class that predicts every head report.
// Depends on rtl/umpq_pkg.sv and rtl/unsorted_max_priority_queue.sv.
`timescale 1ns / 1ps

class umpq_scoreboard;
   localparam int DEPTH = umpq_pkg::DEPTH_DEFAULT;
   localparam int DW    = umpq_pkg::DATA_W;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RSP_W = ((2 * DW + 3 + CNT_W + 7) / 8) * 8;

   typedef struct {
      logic [DW-1:0]    value;
      logic [DW-1:0]    prio;
      logic             valid;
      logic [CNT_W-1:0] total;
      logic             full;
      logic             ok;
   } head_report;

   logic [DW-1:0] slot_value [DEPTH];
   logic [DW-1:0] slot_prio  [DEPTH];
   int            fill;
   head_report    pending_heads [$];
   int            errors;
   int            words_seen;
   int            full_drops;
   int            empty_pops;
   int            clears;
   int            full_reached;

   function int head_slot();
      int best;
      best = 0;
      for (int i = 1; i < fill; i++) begin
         if ($signed(slot_prio[i]) > $signed(slot_prio[best])) best = i;
      end
      return best;
   endfunction

   function void note_request(logic [1:0] mode, logic [DW-1:0] value, logic [DW-1:0] prio);
      head_report rep;
      int         h;
      rep.ok = 1'b0;
      case (mode)
         umpq_pkg::MODE_PUSH: begin
            if (fill < DEPTH) begin
               slot_value[fill] = value;
               slot_prio[fill]  = prio;
               fill++;
               rep.ok = 1'b1;
            end else begin
               full_drops++;
            end
         end
         umpq_pkg::MODE_POP: begin
            if (fill > 0) begin
               for (int i = head_slot(); i + 1 < fill; i++) begin
                  slot_value[i] = slot_value[i+1];
                  slot_prio[i]  = slot_prio[i+1];
               end
               fill--;
               rep.ok = 1'b1;
            end else begin
               empty_pops++;
            end
         end
         umpq_pkg::MODE_CLEAR: begin
            fill   = 0;
            rep.ok = 1'b1;
            clears++;
         end
         default: ;
      endcase
      if (fill > 0) begin
         h         = head_slot();
         rep.value = slot_value[h];
         rep.prio  = slot_prio[h];
         rep.valid = 1'b1;
      end else begin
         rep.value = '0;
         rep.prio  = '0;
         rep.valid = 1'b0;
      end
      rep.total = fill[CNT_W-1:0];
      rep.full  = (fill == DEPTH);
      if (rep.full) full_reached++;
      pending_heads.push_back(rep);
   endfunction

   function void compare_field(string name, logic [DW-1:0] exp_v, logic [DW-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_response(logic [RSP_W-1:0] word);
      head_report rep;
      words_seen++;
      if (pending_heads.size() == 0) begin
         $display("%0t unexpected result: expected none actual %h", $time, word);
         errors++;
         return;
      end
      rep = pending_heads.pop_front();
      compare_field("head_value", rep.value, word[DW-1:0]);
      compare_field("head_priority", rep.prio, word[2*DW-1:DW]);
      compare_field("head_valid", DW'(rep.valid), DW'(word[2*DW]));
      compare_field("entry_total", DW'(rep.total), DW'(word[2*DW+CNT_W:2*DW+1]));
      compare_field("queue_full", DW'(rep.full), DW'(word[2*DW+CNT_W+1]));
      compare_field("accepted", DW'(rep.ok), DW'(word[2*DW+CNT_W+2]));
   endfunction
endclass

module testbench;
   localparam int DEPTH = umpq_pkg::DEPTH_DEFAULT;
   localparam int DW    = umpq_pkg::DATA_W;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RSP_W = ((2 * DW + 3 + CNT_W + 7) / 8) * 8;
   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_WORDS = 332;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [2*DW-1:0]  req_tdata = '0;   // item_value, item_priority
   logic [1:0]       req_tuser = '0;   // mode
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // head_value, head_priority, head_valid,
                                       // entry_total, queue_full, accepted, pad

   int   idle_pct  = 0;
   int   stall_pct = 0;
   logic hold_off  = 1'b0;
   int   words_sent = 0;

   umpq_scoreboard heads;

   unsorted_max_priority_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) heads.check_response(rsp_tdata);
   end

   initial begin
      #(20_000_000);
      $display("[unsorted_max_priority_queue] ERROR");
      $finish;
   end

   task automatic send_word(logic [1:0] mode, logic [DW-1:0] value, logic [DW-1:0] prio);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {prio, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      heads.note_request(mode, value, prio);
      words_sent++;
   endtask

   function automatic logic [DW-1:0] pick_prio();
      case ($urandom_range(0, 3))
         0: return DW'($urandom_range(0, 3));
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic hold_receiver();
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   endtask

   task automatic random_words(int count);
      int push_bias;
      int r;
      push_bias = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: push_bias = 20;
               1: push_bias = 50;
               2: push_bias = 80;
               default: push_bias = 95;
            endcase
         end
         r = $urandom_range(0, 99);
         if (r < 2)
            send_word(umpq_pkg::MODE_CLEAR, $urandom(), $urandom());
         else if (r < 4)
            send_word(MODE_NONE, $urandom(), $urandom());
         else if (r < 4 + push_bias * 96 / 100)
            send_word(umpq_pkg::MODE_PUSH, $urandom(), pick_prio());
         else
            send_word(umpq_pkg::MODE_POP, $urandom(), $urandom());
      end
   endtask

   initial begin
      heads = new;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty-queue corner cases
      send_word(umpq_pkg::MODE_POP, 32'h1234_5678, 32'h7fff_ffff);
      send_word(MODE_NONE, 32'hffff_ffff, 32'hffff_ffff);
      send_word(umpq_pkg::MODE_CLEAR, 32'h0, 32'h0);
      // fill up: extremes and equal priorities
      send_word(umpq_pkg::MODE_PUSH, 32'h7fff_ffff, 32'h8000_0000);
      send_word(umpq_pkg::MODE_PUSH, 32'h8000_0000, 32'h7fff_ffff);
      send_word(umpq_pkg::MODE_PUSH, 32'h0000_0001, 32'h7fff_ffff);
      send_word(umpq_pkg::MODE_PUSH, 32'h0000_0000, 32'h0000_0000);
      send_word(umpq_pkg::MODE_PUSH, 32'hffff_ffff, 32'hffff_ffff);
      for (int i = 0; i < DEPTH - 5; i++)
         send_word(umpq_pkg::MODE_PUSH, $urandom(), DW'($urandom_range(0, 3)));
      send_word(umpq_pkg::MODE_PUSH, 32'haaaa_5555, 32'h7fff_ffff);
      send_word(MODE_NONE, 32'h0, 32'h0);
      send_word(umpq_pkg::MODE_POP, 32'h0, 32'h0);
      send_word(umpq_pkg::MODE_POP, 32'h0, 32'h0);
      send_word(umpq_pkg::MODE_CLEAR, 32'h0, 32'h0);

      // no idling, with one long receiver hold-off
      fork
         random_words(PHASE_WORDS);
         hold_receiver();
      join
      idle_pct  <= 61;
      stall_pct <= 0;
      random_words(PHASE_WORDS);
      idle_pct  <= 0;
      stall_pct <= 61;
      random_words(PHASE_WORDS);
      idle_pct  <= 26;
      stall_pct <= 26;
      random_words(PHASE_WORDS);
      req_tvalid <= 1'b0;
      stall_pct  <= 0;

      while (heads.pending_heads.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);

      $display("Ran %0d words, %0d results checked: %0d clears, %0d pushes dropped on full,",
               words_sent, heads.words_seen, heads.clears, heads.full_drops);
      $display("%0d pops on empty, %0d results at full occupancy; %0d mismatches.",
               heads.empty_pops, heads.full_reached, heads.errors);
      if (heads.errors == 0) begin
         $display("[unsorted_max_priority_queue] OK");
      end else begin
         $display("[unsorted_max_priority_queue] ERROR");
      end
      $finish;
   end
endmodule

// ===== unsorted_max_priority_queue.f =====
rtl/umpq_pkg.sv
rtl/umpq_cell.sv
rtl/unsorted_max_priority_queue.sv
tb/testbench.sv
